@@ src/ppu_pkg.sv @@
// Shared types and constants of the particle update block.
`default_nettype none
package ppu_pkg;

  localparam int DIM_DEFAULT = 16;
  localparam int IDX_W       = 4;
  localparam int DATA_W      = 32;
  localparam int GAIN_W      = 16;
  localparam int RAND_W      = 16;
  localparam int LIMIT_W     = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [DATA_W-1:0] LOW_RESET     = 32'sd0;
  localparam logic signed [DATA_W-1:0] HIGH_RESET    = 32'sd65536;
  localparam logic [LIMIT_W-1:0]       LIMIT_RESET   = 31'd6554;
  localparam logic [GAIN_W-1:0]        INERTIA_RESET = 16'd2949;
  localparam logic [GAIN_W-1:0]        LGAIN_RESET   = 16'd6144;
  localparam logic [GAIN_W-1:0]        GGAIN_RESET   = 16'd6144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW     = 3'd0,
    REG_HIGH    = 3'd1,
    REG_LIMIT   = 3'd2,
    REG_INERTIA = 3'd3,
    REG_LGAIN   = 3'd4,
    REG_GGAIN   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STEP   = 2'd1,
    OP_BEST   = 2'd2,
    OP_UNUSED = 2'd3
  } op_code_t;

  // What the back end has to do with a request.
  typedef enum logic [2:0] {
    K_LOAD,
    K_STEP,
    K_BEST,
    K_SHOW,
    K_NULL
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_K1,
    ST_K2,
    ST_WV,
    ST_T1,
    ST_T2,
    ST_SUM,
    ST_CLAMP,
    ST_REFL,
    ST_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] gbest;
    logic [RAND_W-1:0]        r1;
    logic [RAND_W-1:0]        r2;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
    logic [LIMIT_W-1:0]       limit;
    logic [GAIN_W-1:0]        w;
    logic [GAIN_W-1:0]        c1;
    logic [GAIN_W-1:0]        c2;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] vel;
    logic                     clamped;
    logic                     reflected;
  } result_t;

endpackage
`default_nettype wire

@@ src/ppu_front.sv @@
// Front end: classify incoming requests and hold them in a short queue.
`default_nettype none
module ppu_front #(
  parameter int DIM = ppu_pkg::DIM_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [1:0]                      operation,
  input  wire logic [ppu_pkg::IDX_W-1:0]       dim_index,
  input  wire logic signed [ppu_pkg::DATA_W-1:0] load_value,
  input  wire logic signed [ppu_pkg::DATA_W-1:0] global_best,
  input  wire logic [ppu_pkg::RAND_W-1:0]      rand_local,
  input  wire logic [ppu_pkg::RAND_W-1:0]      rand_global,
  output logic                                 item_valid,
  output ppu_pkg::item_t                       item,
  input  wire logic                            item_take
);

  ppu_pkg::item_t   queue [ppu_pkg::QUEUE_DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  ppu_pkg::item_t   incoming;
  ppu_pkg::kind_t   kind;
  logic             in_range;
  logic             do_push;
  logic             do_pop;

  assign in_range = ({{(32-ppu_pkg::IDX_W){1'b0}}, dim_index} < 32'(DIM));

  always_comb begin
    unique case (ppu_pkg::op_code_t'(operation))
      ppu_pkg::OP_LOAD: kind = ppu_pkg::K_LOAD;
      ppu_pkg::OP_STEP: kind = ppu_pkg::K_STEP;
      ppu_pkg::OP_BEST: kind = ppu_pkg::K_BEST;
      default:          kind = ppu_pkg::K_SHOW;
    endcase
    if (!in_range) kind = ppu_pkg::K_NULL;
  end

  always_comb begin
    incoming.kind  = kind;
    incoming.idx   = dim_index;
    incoming.value = load_value;
    incoming.gbest = global_best;
    incoming.r1    = rand_local;
    incoming.r2    = rand_global;
  end

  assign full       = (count == 2'(ppu_pkg::QUEUE_DEPTH));
  assign item_valid = (count != 2'd0);
  assign item       = queue[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_valid && item_take;

  always_ff @(posedge clk) begin
    if (do_push) queue[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ src/ppu_back.sv @@
// Back end: per-dimension stores, shared multiplier sequencer and result register.
`default_nettype none
module ppu_back #(
  parameter int DIM = ppu_pkg::DIM_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ppu_pkg::cfg_t    cfg,
  input  wire logic             item_valid,
  input  wire ppu_pkg::item_t   item,
  output logic                  item_take,
  output logic                  res_valid,
  output ppu_pkg::result_t      res,
  input  wire logic             res_pop
);

  localparam int SPAN  = 1 << ppu_pkg::IDX_W;
  localparam int DEPTH = (DIM < SPAN) ? DIM : SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] pos_store  [DEPTH];
  logic signed [31:0] vel_store  [DEPTH];
  logic signed [31:0] best_store [DEPTH];
  logic [DEPTH-1:0]   vel_valid;

  ppu_pkg::state_t    state, state_next;
  ppu_pkg::item_t     cur;
  logic [AW-1:0]      addr;
  logic signed [31:0] x_rd, v_rd, b_rd;

  logic signed [31:0] xr;
  logic signed [31:0] vel;
  logic signed [32:0] d1, d2;
  logic [15:0]        k1, k2;
  logic signed [49:0] prod;
  logic signed [39:0] acc;
  logic signed [35:0] posw;
  logic               clamped, reflected;

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [39:0] term;
  logic signed [39:0] lim40;
  logic signed [35:0] low36, high36, pw, sat;
  logic               fire;

  assign addr = cur.idx[AW-1:0];
  assign x_rd = pos_store[addr];
  assign b_rd = best_store[addr];
  assign v_rd = vel_valid[addr] ? vel_store[addr] : 32'sd0;

  // Floor shift by 12 of the registered product.
  assign term   = 40'(prod >>> 12);
  assign lim40  = 40'(signed'({1'b0, cfg.limit}));
  assign low36  = 36'(cfg.low);
  assign high36 = 36'(cfg.high);
  assign pw     = 36'(xr) + 36'(vel);

  always_comb begin
    sat = (posw < low36) ? low36 : posw;
    if (sat > high36) sat = high36;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ppu_pkg::ST_IDLE:  if (item_valid) state_next = ppu_pkg::ST_FETCH;
      ppu_pkg::ST_FETCH: state_next = (cur.kind == ppu_pkg::K_STEP) ?
                                      ppu_pkg::ST_K1 : ppu_pkg::ST_OUT;
      ppu_pkg::ST_K1:    state_next = ppu_pkg::ST_K2;
      ppu_pkg::ST_K2:    state_next = ppu_pkg::ST_WV;
      ppu_pkg::ST_WV:    state_next = ppu_pkg::ST_T1;
      ppu_pkg::ST_T1:    state_next = ppu_pkg::ST_T2;
      ppu_pkg::ST_T2:    state_next = ppu_pkg::ST_SUM;
      ppu_pkg::ST_SUM:   state_next = ppu_pkg::ST_CLAMP;
      ppu_pkg::ST_CLAMP: state_next = ppu_pkg::ST_REFL;
      ppu_pkg::ST_REFL:  state_next = ppu_pkg::ST_SAT;
      ppu_pkg::ST_SAT:   state_next = ppu_pkg::ST_OUT;
      ppu_pkg::ST_OUT:   if (!res_valid || res_pop) state_next = ppu_pkg::ST_IDLE;
      default:           state_next = ppu_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operand select.
  always_comb begin
    item_take = (state == ppu_pkg::ST_IDLE) && item_valid;
    fire      = (state == ppu_pkg::ST_OUT) && (!res_valid || res_pop);
    mul_a     = 17'sd0;
    mul_b     = 33'sd0;
    unique case (state)
      ppu_pkg::ST_K1: begin
        mul_a = signed'({1'b0, cfg.c1});
        mul_b = signed'({17'd0, cur.r1});
      end
      ppu_pkg::ST_K2: begin
        mul_a = signed'({1'b0, cfg.c2});
        mul_b = signed'({17'd0, cur.r2});
      end
      ppu_pkg::ST_WV: begin
        mul_a = signed'({1'b0, cfg.w});
        mul_b = 33'(vel);
      end
      ppu_pkg::ST_T1: begin
        mul_a = signed'({1'b0, k1});
        mul_b = d1;
      end
      ppu_pkg::ST_T2: begin
        mul_a = signed'({1'b0, k2});
        mul_b = d2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ppu_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath of one request.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (item_take) cur <= item;
    unique case (state)
      ppu_pkg::ST_FETCH: begin
        clamped   <= 1'b0;
        reflected <= 1'b0;
        xr        <= x_rd;
        d1        <= 33'(b_rd) - 33'(x_rd);
        d2        <= 33'(cur.gbest) - 33'(x_rd);
        unique case (cur.kind)
          ppu_pkg::K_LOAD: begin
            posw <= 36'(cur.value);
            vel  <= 32'sd0;
          end
          ppu_pkg::K_NULL: begin
            posw <= 36'sd0;
            vel  <= 32'sd0;
          end
          default: begin
            posw <= 36'(x_rd);
            vel  <= v_rd;
          end
        endcase
      end
      ppu_pkg::ST_K2:  k1 <= prod[31:16];
      ppu_pkg::ST_WV:  k2 <= prod[31:16];
      ppu_pkg::ST_T1:  acc <= term;
      ppu_pkg::ST_T2:  acc <= acc + term;
      ppu_pkg::ST_SUM: acc <= acc + term;
      ppu_pkg::ST_CLAMP: begin
        if (acc > lim40) begin
          vel     <= signed'({1'b0, cfg.limit});
          clamped <= 1'b1;
        end else if (acc < -lim40) begin
          vel     <= -signed'({1'b0, cfg.limit});
          clamped <= 1'b1;
        end else begin
          vel <= acc[31:0];
        end
      end
      ppu_pkg::ST_REFL: begin
        if (pw < low36) begin
          posw      <= (low36 <<< 1) - pw;
          vel       <= -vel;
          reflected <= 1'b1;
        end else if (pw > high36) begin
          posw      <= (high36 <<< 1) - pw;
          vel       <= -vel;
          reflected <= 1'b1;
        end else begin
          posw <= pw;
        end
      end
      ppu_pkg::ST_SAT: posw <= sat;
      default: ;
    endcase
  end

  // Store writes take effect as the result is handed over.
  always_ff @(posedge clk) begin
    if (fire) begin
      case (cur.kind)
        ppu_pkg::K_LOAD: begin
          pos_store[addr]  <= cur.value;
          best_store[addr] <= cur.value;
          vel_store[addr]  <= 32'sd0;
        end
        ppu_pkg::K_BEST: best_store[addr] <= cur.value;
        ppu_pkg::K_STEP: begin
          pos_store[addr] <= posw[31:0];
          vel_store[addr] <= vel;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_valid <= '0;
    end else if (fire && (cur.kind == ppu_pkg::K_LOAD || cur.kind == ppu_pkg::K_STEP)) begin
      vel_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.idx       <= cur.idx;
      res.pos       <= posw[31:0];
      res.vel       <= vel;
      res.clamped   <= clamped;
      res.reflected <= reflected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)          res_valid <= 1'b0;
    else if (fire)    res_valid <= 1'b1;
    else if (res_pop) res_valid <= 1'b0;
  end

  a_clamp_magnitude: assert property (@(posedge clk) disable iff (rst)
    (state == ppu_pkg::ST_REFL && clamped) |->
      (vel == signed'({1'b0, cfg.limit}) || vel == -signed'({1'b0, cfg.limit})))
    else $error("clamped velocity does not sit on the speed limit");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ppu_pkg::ST_OUT && cur.kind == ppu_pkg::K_STEP && cfg.low <= cfg.high) |->
      (posw >= low36 && posw <= high36))
    else $error("stepped position left the search range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ppu_pkg::ST_OUT))
    else $error("result appeared without a finished request");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    item_take |=> (state == ppu_pkg::ST_FETCH))
    else $error("taken request did not enter fetch");

endmodule
`default_nettype wire

@@ src/pso_particle_update.sv @@
// Top level of the particle update block: configuration registers, front and back ends.
//
// Usage:
//   Requests enter through a queue-like port: drive the fields and raise push;
//   a request is taken at a clock edge with push high and full low. The front
//   end classifies each request and holds up to two in a small queue.
//   Results leave through a queue-like port: while empty is low the oldest
//   result sits on out_index, new_position, new_velocity, was_clamped and
//   was_reflected; pop at an edge with empty low takes it.
//   Every request gives exactly one result, in request order.
// Sequencing:
//   The back end works on one request at a time. A step walks five products
//   through one shared 17x33 multiplier, then clamp, reflect and saturate.
//   Load, set-best, unused-code and out-of-range requests skip the multiplier
//   and go straight from fetch to the output state. The shared multiplier
//   sequence sets the step rate.
// Reset and stalls:
//   rst (synchronous) restores register defaults, zeroes all velocities and
//   empties both queues. When the receiver holds off pop, the finished result
//   waits in the output register; the back end stalls on its next result, and
//   the front queue keeps taking requests until it is full.
// Configuration: write cfg_data to register cfg_index when cfg_write is high,
//   only while no request is in flight.
`default_nettype none
module pso_particle_update #(
  parameter int DIM = ppu_pkg::DIM_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ppu_pkg::DATA_W-1:0]          cfg_data,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [1:0]                          operation,
  input  wire logic [ppu_pkg::IDX_W-1:0]           dim_index,
  input  wire logic signed [ppu_pkg::DATA_W-1:0]   load_value,
  input  wire logic signed [ppu_pkg::DATA_W-1:0]   global_best,
  input  wire logic [ppu_pkg::RAND_W-1:0]          rand_local,
  input  wire logic [ppu_pkg::RAND_W-1:0]          rand_global,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [ppu_pkg::IDX_W-1:0]                out_index,
  output logic signed [ppu_pkg::DATA_W-1:0]        new_position,
  output logic signed [ppu_pkg::DATA_W-1:0]        new_velocity,
  output logic                                     was_clamped,
  output logic                                     was_reflected
);

  ppu_pkg::cfg_t    cfg;
  ppu_pkg::item_t   item;
  ppu_pkg::result_t res;
  logic             item_valid;
  logic             item_take;
  logic             res_valid;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low   <= ppu_pkg::LOW_RESET;
      cfg.high  <= ppu_pkg::HIGH_RESET;
      cfg.limit <= ppu_pkg::LIMIT_RESET;
      cfg.w     <= ppu_pkg::INERTIA_RESET;
      cfg.c1    <= ppu_pkg::LGAIN_RESET;
      cfg.c2    <= ppu_pkg::GGAIN_RESET;
    end else if (cfg_write) begin
      unique case (ppu_pkg::cfg_reg_t'(cfg_index))
        ppu_pkg::REG_LOW:     cfg.low   <= cfg_data;
        ppu_pkg::REG_HIGH:    cfg.high  <= cfg_data;
        ppu_pkg::REG_LIMIT:   cfg.limit <= cfg_data[ppu_pkg::LIMIT_W-1:0];
        ppu_pkg::REG_INERTIA: cfg.w     <= cfg_data[ppu_pkg::GAIN_W-1:0];
        ppu_pkg::REG_LGAIN:   cfg.c1    <= cfg_data[ppu_pkg::GAIN_W-1:0];
        ppu_pkg::REG_GGAIN:   cfg.c2    <= cfg_data[ppu_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ppu_front #(.DIM(DIM)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .dim_index   (dim_index),
    .load_value  (load_value),
    .global_best (global_best),
    .rand_local  (rand_local),
    .rand_global (rand_global),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  ppu_back #(.DIM(DIM)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop)
  );

  assign empty         = !res_valid;
  assign out_index     = res.idx;
  assign new_position  = res.pos;
  assign new_velocity  = res.vel;
  assign was_clamped   = res.clamped;
  assign was_reflected = res.reflected;

endmodule
`default_nettype wire

@@ tb/ppu_checker.sv @@
// Checker for the particle update block: predicts every result and compares it.
`default_nettype none
module ppu_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [1:0]  operation,
  input  wire logic [3:0]  dim_index,
  input  wire logic [31:0] load_value,
  input  wire logic [31:0] global_best,
  input  wire logic [15:0] rand_local,
  input  wire logic [15:0] rand_global,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [3:0]  out_index,
  input  wire logic [31:0] new_position,
  input  wire logic [31:0] new_velocity,
  input  wire logic        was_clamped,
  input  wire logic        was_reflected,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        clamped;
    logic        reflected;
  } particle_result_t;

  particle_result_t awaited_results[$];

  logic signed [63:0] low_bound, high_bound, speed_cap;
  logic [15:0]        inertia_w, gain_c1, gain_c2;
  logic signed [31:0] pos_mem[16], vel_mem[16], best_mem[16];

  assign pending = awaited_results.size();

  function automatic logic signed [63:0] floor_div4096(logic signed [63:0] x);
    return x >>> 12;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic apply_request();
    particle_result_t r;
    logic signed [63:0] x, v, pb, gb, k1, k2, vsum, p;
    r = '{dim_index, 32'd0, 32'd0, 1'b0, 1'b0};
    case (operation)
      ppu_pkg::OP_LOAD: begin
        pos_mem[dim_index] = load_value;
        best_mem[dim_index] = load_value;
        vel_mem[dim_index] = 0;
      end
      ppu_pkg::OP_BEST: best_mem[dim_index] = load_value;
      ppu_pkg::OP_STEP: begin
        x = 64'(pos_mem[dim_index]);
        v = 64'(vel_mem[dim_index]);
        pb = 64'(best_mem[dim_index]);
        gb = 64'(signed'(global_best));
        k1 = 64'((32'(gain_c1) * 32'(rand_local)) >> 16);
        k2 = 64'((32'(gain_c2) * 32'(rand_global)) >> 16);
        vsum = floor_div4096(64'(inertia_w) * v) + floor_div4096(k1 * (pb - x))
             + floor_div4096(k2 * (gb - x));
        if (vsum > speed_cap) begin
          vsum = speed_cap;
          r.clamped = 1'b1;
        end else if (vsum < -speed_cap) begin
          vsum = -speed_cap;
          r.clamped = 1'b1;
        end
        p = x + vsum;
        // reflect about whichever bound was crossed, then saturate
        if (p < low_bound) begin
          p = 2 * low_bound - p;
          vsum = -vsum;
          r.reflected = 1'b1;
        end else if (p > high_bound) begin
          p = 2 * high_bound - p;
          vsum = -vsum;
          r.reflected = 1'b1;
        end
        if (p < low_bound) p = low_bound;
        if (p > high_bound) p = high_bound;
        pos_mem[dim_index] = p[31:0];
        vel_mem[dim_index] = vsum[31:0];
      end
      default: ;
    endcase
    r.pos = pos_mem[dim_index];
    r.vel = vel_mem[dim_index];
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin
    particle_result_t want;
    if (rst) begin
      fail_count = 0;
      low_bound = 64'(signed'(ppu_pkg::LOW_RESET));
      high_bound = 64'(signed'(ppu_pkg::HIGH_RESET));
      speed_cap = 64'(ppu_pkg::LIMIT_RESET);
      inertia_w = ppu_pkg::INERTIA_RESET;
      gain_c1 = ppu_pkg::LGAIN_RESET;
      gain_c2 = ppu_pkg::GGAIN_RESET;
      foreach (vel_mem[i]) begin
        vel_mem[i] = 0;
        pos_mem[i] = 0;
        best_mem[i] = 0;
      end
    end else begin
      if (cfg_write) begin
        case (ppu_pkg::cfg_reg_t'(cfg_index))
          ppu_pkg::REG_LOW:     low_bound = 64'(signed'(cfg_data));
          ppu_pkg::REG_HIGH:    high_bound = 64'(signed'(cfg_data));
          ppu_pkg::REG_LIMIT:   speed_cap = 64'(cfg_data[30:0]);
          ppu_pkg::REG_INERTIA: inertia_w = cfg_data[15:0];
          ppu_pkg::REG_LGAIN:   gain_c1 = cfg_data[15:0];
          ppu_pkg::REG_GGAIN:   gain_c2 = cfg_data[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report("unexpected result", 32'(out_index), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_index !== want.idx) report("out_index", 32'(out_index), 32'(want.idx));
          if (new_position !== want.pos) report("new_position", new_position, want.pos);
          if (new_velocity !== want.vel) report("new_velocity", new_velocity, want.vel);
          if (was_clamped !== want.clamped)
            report("was_clamped", 32'(was_clamped), 32'(want.clamped));
          if (was_reflected !== want.reflected)
            report("was_reflected", 32'(was_reflected), 32'(want.reflected));
        end
      end
      if (push && !full) apply_request();
    end
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Top of the particle update testbench: clock, reset, stimulus and verdict.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation = ppu_pkg::OP_LOAD;
  logic [3:0]  dim_index = '0;
  logic [31:0] load_value = '0;
  logic [31:0] global_best = '0;
  logic [15:0] rand_local = '0;
  logic [15:0] rand_global = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_index;
  logic [31:0] new_position, new_velocity;
  logic        was_clamped, was_reflected;
  int          fail_count, pending;
  int          hold_pop = 0;    // cycles the receiver must hold off
  int          rest_pop = 0;    // occasional random long pause of the receiver
  bit          loaded[16];      // dimensions whose position and best are known

  always #5 clk = ~clk;

  pso_particle_update DUT (.*);
  ppu_checker checker_i (.*);

  // Receiver: random pops, with an enforced long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_pop > 0) begin
      hold_pop <= hold_pop - 1;
      pop <= 1'b0;
    end else if (rest_pop > 0) begin
      rest_pop <= rest_pop - 1;
      pop <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          pop <= 1'b0;
          if ($urandom_range(0, 9) == 0) rest_pop <= $urandom_range(10, 40);
        end
        1, 2:    pop <= 1'b0;
        default: pop <= 1'b1;
      endcase
    end
  end

  // Drive one request and hold it until taken; push stays high for the next one.
  task automatic send_request(logic [1:0] op, logic [3:0] idx, logic [31:0] val,
                              logic [31:0] gb, logic [15:0] r1, logic [15:0] r2);
    push <= 1'b1;
    operation <= op;
    dim_index <= idx;
    load_value <= val;
    global_best <= gb;
    rand_local <= r1;
    rand_global <= r2;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op == ppu_pkg::OP_LOAD) loaded[idx] = 1'b1;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come.
  task automatic wait_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Wait until every result is in, then let any in-flight work drain.
  task automatic drain();
    wait_results();
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(ppu_pkg::cfg_reg_t r, logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return 32'h8000_0000 | $urandom_range(0, 3);
      2:       return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 262144)) - 65536);
    endcase
  endfunction

  // One random request; anything but a load only on loaded dimensions.
  task automatic random_request();
    logic [1:0] op;
    logic [3:0] idx;
    idx = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0, 1:    op = ppu_pkg::OP_LOAD;
      2:       op = ppu_pkg::OP_BEST;
      3:       op = ppu_pkg::OP_UNUSED;
      default: op = ppu_pkg::OP_STEP;
    endcase
    if (op != ppu_pkg::OP_LOAD && !loaded[idx]) op = ppu_pkg::OP_LOAD;
    send_request(op, idx, pick_value(), pick_value(), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_config(bit extreme);
    logic signed [31:0] a, b;
    if (extreme) begin
      write_reg(ppu_pkg::REG_LOW, 32'h8000_0000);
      write_reg(ppu_pkg::REG_HIGH, 32'h7fff_ffff);
      write_reg(ppu_pkg::REG_LIMIT, 32'h7fff_ffff);
      write_reg(ppu_pkg::REG_INERTIA, 32'h0000_ffff);
      write_reg(ppu_pkg::REG_LGAIN, 32'h0000_ffff);
      write_reg(ppu_pkg::REG_GGAIN, 32'h0000_ffff);
    end else begin
      a = pick_value();
      b = pick_value();
      // mostly an ordered range, sometimes inverted
      if (a > b && $urandom_range(0, 4) != 0) begin
        write_reg(ppu_pkg::REG_LOW, b);
        write_reg(ppu_pkg::REG_HIGH, a);
      end else begin
        write_reg(ppu_pkg::REG_LOW, a);
        write_reg(ppu_pkg::REG_HIGH, b);
      end
      write_reg(ppu_pkg::REG_LIMIT, ($urandom_range(0, 3) == 0) ? {1'b0, 31'($urandom)}
                                                       : 32'($urandom_range(0, 200000)));
      write_reg(ppu_pkg::REG_INERTIA, $urandom_range(0, 1) ? 32'(16'($urandom))
                                                           : 32'($urandom_range(0, 4096)));
      write_reg(ppu_pkg::REG_LGAIN, $urandom_range(0, 5) == 0 ? 32'd0 : 32'(16'($urandom)));
      write_reg(ppu_pkg::REG_GGAIN, $urandom_range(0, 5) == 0 ? 32'd0 : 32'(16'($urandom)));
    end
  endtask

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: loads at extremes, every operation, unused code, range edges.
    send_request(ppu_pkg::OP_LOAD, 4'd0, 32'd0, 32'd0, 16'd0, 16'd0);
    send_request(ppu_pkg::OP_LOAD, 4'd15, 32'h0000_8000, 32'd0, 16'd0, 16'd0);
    send_request(ppu_pkg::OP_STEP, 4'd0, 32'd0, 32'h0001_0000, 16'hffff, 16'hffff);
    send_request(ppu_pkg::OP_STEP, 4'd15, 32'd0, 32'h8000_0000, 16'hffff, 16'hffff);
    send_request(ppu_pkg::OP_BEST, 4'd15, 32'h7fff_ffff, 32'd0, 16'd0, 16'd0);
    send_request(ppu_pkg::OP_STEP, 4'd15, 32'd0, 32'h7fff_ffff, 16'hffff, 16'h0);
    send_request(ppu_pkg::OP_UNUSED, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    send_request(ppu_pkg::OP_LOAD, 4'd7, 32'hffff_0000, 32'd0, 16'd0, 16'd0);
    send_request(ppu_pkg::OP_STEP, 4'd7, 32'd0, 32'h0000_0000, 16'd0, 16'd0);
    drain();
    random_config(1'b1);
    send_request(ppu_pkg::OP_LOAD, 4'd3, 32'h8000_0000, 32'd0, 16'd0, 16'd0);
    send_request(ppu_pkg::OP_STEP, 4'd3, 32'd0, 32'h7fff_ffff, 16'hffff, 16'hffff);
    send_request(ppu_pkg::OP_LOAD, 4'd4, 32'h7fff_ffff, 32'd0, 16'd0, 16'd0);
    send_request(ppu_pkg::OP_STEP, 4'd4, 32'd0, 32'h8000_0000, 16'hffff, 16'hffff);
    send_request(ppu_pkg::OP_STEP, 4'd4, 32'd0, 32'h8000_0000, 16'h8000, 16'h5555);
    drain();
    // zero limit and an inverted range
    write_reg(ppu_pkg::REG_LIMIT, 32'd0);
    write_reg(ppu_pkg::REG_LOW, 32'h0001_0000);
    write_reg(ppu_pkg::REG_HIGH, 32'hffff_0000);
    send_request(ppu_pkg::OP_STEP, 4'd3, 32'd0, 32'h1234_5678, 16'hffff, 16'hffff);
    send_request(ppu_pkg::OP_STEP, 4'd4, 32'd0, 32'h1234_5678, 16'hffff, 16'hffff);
    drain();

    // Random phases with a new setting between each.
    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase == 5);
      for (int n = 0; n < 150; n++) begin
        random_request();
        if (phase == 3 && n == 40) hold_pop = 200;  // back up the block
        if (phase == 6 && n == 60) wait_results();
        if (phase != 3 && phase != 8) idle_gap();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
